FILE: rtl/core/dispense_valve_phase_sequencer_assert.svh
// ----------------------------------------------------------------------------
// dispense_valve_phase_sequencer_assert: assertion macros
// Implication and next-cycle implication checks on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DISPENSE_VALVE_PHASE_SEQUENCER_ASSERT_SVH
`define DISPENSE_VALVE_PHASE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define DVPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DVPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DVPS_ASSERT_IMP(lbl, ante, cons, msg)
`define DVPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/dvps_pkg.sv
// ----------------------------------------------------------------------------
// dvps_pkg: dispense valve phase sequencer package
// Sizes, codes, register types and phase split functions.
// ----------------------------------------------------------------------------
package dvps_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 7;
    localparam int CNT_W       = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;
    localparam int POS_W       = 6;

    localparam logic [DATA_W-1:0] HOLD_NO_PULSE = '1;
    localparam logic [DATA_W-1:0] BOOST_RESET   = 32'd0;
    localparam logic [DATA_W-1:0] HOLD_RESET    = 32'd3000;
    localparam logic [LEN_W-1:0]  SEQ_LEN_RESET = 7'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BOOST  = 3'd1,
        PH_STEADY = 3'd2,
        PH_PULSED = 3'd3,
        PH_GAP    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_PULSED = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_BOOST   = 2'd0,
        REG_HOLD    = 2'd1,
        REG_SEQ_LEN = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_READY,
        S_EXEC,
        S_SEEK_INIT,
        S_SEEK_RD,
        S_SEEK_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] boost_time;
        logic [DATA_W-1:0] hold_time;
        logic [LEN_W-1:0]  seq_len;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        t_phase            phase;
        logic [DATA_W-1:0] ticks;
        logic [DATA_W-1:0] rem;
    } t_phase_load;

    // steady part up to hold time, pulsed for the rest
    function automatic t_phase_load main_split(input logic [DATA_W-1:0] rest,
                                               input logic [DATA_W-1:0] hold);
        t_phase_load       r;
        logic [DATA_W-1:0] steady;
        steady = (hold == HOLD_NO_PULSE || rest <= hold) ? rest : hold;
        r.hit  = (rest != '0);
        if (steady != '0) begin
            r.phase = PH_STEADY;
            r.ticks = steady;
            r.rem   = rest - steady;
        end else begin
            r.phase = PH_PULSED;
            r.ticks = rest;
            r.rem   = '0;
        end
        return r;
    endfunction

    function automatic t_phase_load entry_split(input logic [DATA_W-1:0] v,
                                                input logic              odd,
                                                input t_cfg              cfg);
        t_phase_load       r;
        logic [DATA_W-1:0] b;
        b = (cfg.boost_time < v) ? cfg.boost_time : v;
        if (odd) begin
            r.hit   = (v != '0);
            r.phase = PH_GAP;
            r.ticks = v;
            r.rem   = '0;
        end else if (b != '0) begin
            r.hit   = 1'b1;
            r.phase = PH_BOOST;
            r.ticks = b;
            r.rem   = v - b;
        end else begin
            r = main_split(v, cfg.hold_time);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/dvps_regs.sv
// ----------------------------------------------------------------------------
// dvps_regs: configuration register file
// APB-style write and read of boost time, hold time and sequence length.
// ----------------------------------------------------------------------------
module dvps_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dvps_pkg::PADDR_W-1:0] paddr,
    input  logic [dvps_pkg::DATA_W-1:0]  pwdata,
    output logic [dvps_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output dvps_pkg::t_cfg               o_cfg
);
    import dvps_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_BOOST:   n_cfg.boost_time = pwdata;
                REG_HOLD:    n_cfg.hold_time  = pwdata;
                REG_SEQ_LEN: n_cfg.seq_len    = pwdata[LEN_W-1:0];
                default:     n_cfg            = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BOOST:   prdata = r_cfg.boost_time;
            REG_HOLD:    prdata = r_cfg.hold_time;
            REG_SEQ_LEN: prdata = DATA_W'(r_cfg.seq_len);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boost_time <= BOOST_RESET;
            r_cfg.hold_time  <= HOLD_RESET;
            r_cfg.seq_len    <= SEQ_LEN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/core/dispense_valve_phase_sequencer.sv
// ----------------------------------------------------------------------------
// dispense_valve_phase_sequencer: tick-driven dispense valve phase sequencer
// Flow: a write, stop or plain tick passes S_EXEC and S_DONE before o_valid rises;
//   a start, or an interval-ending tick, adds S_SEEK_INIT and an S_SEEK_RD/S_SEEK_EV
//   pair per entry searched. One item at a time; the search reads one entry per
//   S_SEEK_RD/S_SEEK_EV pair through the single registered table read port.
// Reset: synchronous active low; registers to defaults, sequencer idle and
//   stopped; the interval table is undefined until written.
// ----------------------------------------------------------------------------
`include "dispense_valve_phase_sequencer_assert.svh"

module dispense_valve_phase_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dvps_pkg::PADDR_W-1:0] paddr,
    input  logic [dvps_pkg::DATA_W-1:0]  pwdata,
    output logic [dvps_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic [5:0]                   i_entry_index,
    input  logic [dvps_pkg::DATA_W-1:0]  i_entry_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_boost_valve,
    output logic [1:0]                   o_main_valve_mode,
    output logic                         o_running,
    output logic [2:0]                   o_phase,
    output logic [dvps_pkg::POS_W-1:0]   o_step_position
);
    import dvps_pkg::*;

    t_cfg w_cfg;

    dvps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [5:0]        r_idx;
    logic [DATA_W-1:0] r_val;
    logic              r_running, n_running;
    t_phase            r_phase, n_phase;
    logic [DATA_W-1:0] r_ticks, n_ticks;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [ADDR_W-1:0] r_entry, n_entry;
    logic [CNT_W-1:0]  r_seek_entry, n_seek_entry;
    logic [CNT_W-1:0]  r_seek_cnt, n_seek_cnt;

    logic              r_out_valid;
    logic              r_out_boost;
    t_mode             r_out_mode;
    logic              r_out_running;
    t_phase            r_out_phase;
    logic [POS_W-1:0]  r_out_pos;

    logic              w_accept;
    logic              w_out_load;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [CNT_W-1:0]  w_used;
    logic [CNT_W-1:0]  w_widx;
    logic              w_widx_ok;
    logic [CNT_W-1:0]  w_entry_ext;
    logic              w_tick_end;
    logic              w_tick_more;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [CNT_W-1:0]  w_seek_inc;
    t_phase_load       w_main;
    t_phase_load       w_ent;
    t_mode             w_mode;

    assign w_used      = (CNT_W'(w_cfg.seq_len) > CNT_W'(TABLE_DEPTH)) ?
                         CNT_W'(TABLE_DEPTH) : CNT_W'(w_cfg.seq_len);
    assign w_widx      = CNT_W'(r_idx);
    assign w_widx_ok   = (w_widx < CNT_W'(TABLE_DEPTH));
    assign w_entry_ext = CNT_W'(r_entry);
    assign w_tick_end  = (r_ticks <= DATA_W'(1));
    assign w_main      = main_split(r_rem, w_cfg.hold_time);
    assign w_ent       = entry_split(r_rdata, r_seek_entry[0], w_cfg);
    assign w_cnt_inc   = r_seek_cnt + CNT_W'(1);
    assign w_seek_inc  = r_seek_entry + CNT_W'(1);
    assign w_tick_more = (r_phase == PH_BOOST && w_main.hit) ||
                         (r_phase == PH_STEADY && r_rem != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_READY: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_op)
                    OP_WRITE: n_state = S_DONE;
                    OP_STOP:  n_state = S_DONE;
                    OP_START: n_state = S_SEEK_INIT;
                    OP_TICK: begin
                        if (!r_running) n_state = S_DONE;
                        else if (r_phase == PH_IDLE) n_state = S_SEEK_INIT;
                        else if (w_tick_end && !w_tick_more) n_state = S_SEEK_INIT;
                        else n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SEEK_INIT: begin
                n_state = (w_used == '0) ? S_DONE : S_SEEK_RD;
            end
            S_SEEK_RD: n_state = S_SEEK_EV;
            S_SEEK_EV: begin
                n_state = (w_ent.hit || w_cnt_inc == w_used) ? S_DONE : S_SEEK_RD;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) n_state = S_READY;
            end
            default: n_state = S_READY;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall    = (r_state != S_READY);
        w_accept   = (r_state == S_READY) && i_valid;
        w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);
        w_mem_we   = (r_state == S_EXEC) && (r_op == OP_WRITE) && w_widx_ok;
        w_mem_re   = (r_state == S_SEEK_RD);
    end

    // sequencer datapath
    always_comb begin
        n_running    = r_running;
        n_phase      = r_phase;
        n_ticks      = r_ticks;
        n_rem        = r_rem;
        n_entry      = r_entry;
        n_seek_entry = r_seek_entry;
        n_seek_cnt   = r_seek_cnt;
        case (r_state)
            S_EXEC: begin
                case (r_op)
                    OP_STOP: begin
                        n_running = 1'b0;
                        n_phase   = PH_IDLE;
                        n_ticks   = '0;
                        n_rem     = '0;
                        n_entry   = '0;
                    end
                    OP_START: begin
                        n_running    = 1'b1;
                        n_seek_entry = '0;
                    end
                    OP_TICK: begin
                        if (r_running) begin
                            if (r_phase == PH_IDLE) begin
                                n_seek_entry = '0;
                            end else if (!w_tick_end) begin
                                n_ticks = r_ticks - DATA_W'(1);
                            end else if (r_phase == PH_BOOST && w_main.hit) begin
                                n_phase = w_main.phase;
                                n_ticks = w_main.ticks;
                                n_rem   = w_main.rem;
                            end else if (r_phase == PH_STEADY && r_rem != '0) begin
                                n_phase = PH_PULSED;
                                n_ticks = r_rem;
                                n_rem   = '0;
                            end else begin
                                n_seek_entry = w_entry_ext + CNT_W'(1);
                            end
                        end
                    end
                    default: n_running = r_running;
                endcase
            end
            S_SEEK_INIT: begin
                if (w_used == '0) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                    n_rem   = '0;
                    n_entry = '0;
                end else begin
                    if (r_seek_entry >= w_used) n_seek_entry = '0;
                    n_seek_cnt = '0;
                end
            end
            S_SEEK_EV: begin
                if (w_ent.hit) begin
                    n_phase = w_ent.phase;
                    n_ticks = w_ent.ticks;
                    n_rem   = w_ent.rem;
                    n_entry = r_seek_entry[ADDR_W-1:0];
                end else if (w_cnt_inc == w_used) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                    n_rem   = '0;
                    n_entry = '0;
                end else begin
                    n_seek_cnt   = w_cnt_inc;
                    n_seek_entry = (w_seek_inc >= w_used) ? '0 : w_seek_inc;
                end
            end
            default: n_running = r_running;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_STEADY: w_mode = MODE_STEADY;
            PH_PULSED: w_mode = MODE_PULSED;
            default:   w_mode = MODE_CLOSED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) mem[w_widx[ADDR_W-1:0]] <= r_val;
        if (w_mem_re) r_rdata <= mem[r_seek_entry[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(i_op);
            r_idx <= i_entry_index;
            r_val <= i_entry_value;
        end
        if (w_out_load) begin
            r_out_boost   <= (r_phase == PH_BOOST);
            r_out_mode    <= w_mode;
            r_out_running <= r_running;
            r_out_phase   <= r_phase;
            r_out_pos     <= w_entry_ext[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_READY;
            r_running    <= 1'b0;
            r_phase      <= PH_IDLE;
            r_ticks      <= '0;
            r_rem        <= '0;
            r_entry      <= '0;
            r_seek_entry <= '0;
            r_seek_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_running    <= n_running;
            r_phase      <= n_phase;
            r_ticks      <= n_ticks;
            r_rem        <= n_rem;
            r_entry      <= n_entry;
            r_seek_entry <= n_seek_entry;
            r_seek_cnt   <= n_seek_cnt;
            if (w_out_load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_boost_valve     = r_out_boost;
    assign o_main_valve_mode = r_out_mode;
    assign o_running         = r_out_running;
    assign o_phase           = r_out_phase;
    assign o_step_position   = r_out_pos;

    `DVPS_ASSERT_IMP(a_phase_needs_run, r_phase != PH_IDLE, r_running, "phase active while stopped")
    `DVPS_ASSERT_IMP(a_phase_ticks, r_phase != PH_IDLE, r_ticks != '0, "active phase with no ticks")
    `DVPS_ASSERT_IMP(a_gap_odd, r_phase == PH_GAP, r_entry[0], "gap phase on even entry")
    `DVPS_ASSERT_IMP(a_pulsed_last, r_phase == PH_PULSED, r_rem == '0, "pulsed phase with remainder")
    `DVPS_ASSERT_NXT(a_stop_idle, r_state == S_EXEC && r_op == OP_STOP, !r_running && r_phase == PH_IDLE, "stop did not idle")

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: dispense valve phase sequencer testbench
// Loads the interval table, runs directed phase sequences and special cases,
// then random ops under several idle/stall mixes and a long output hold-off.
// Every transfer is predicted in order and each output transfer is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dvps_pkg::*;

    typedef struct packed {
        logic         boost;
        t_mode        mode;
        logic         running;
        t_phase       phase;
        logic [5:0]   pos;
    } t_valve_state;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [1:0]          i_op          = '0;
    logic [5:0]          i_entry_index = '0;
    logic [DATA_W-1:0]   i_entry_value = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic                o_boost_valve;
    logic [1:0]          o_main_valve_mode;
    logic                o_running;
    logic [2:0]          o_phase;
    logic [POS_W-1:0]    o_step_position;

    // predictor state
    logic [31:0]         seq_table [TABLE_DEPTH];
    logic [31:0]         ph_ticks;
    logic [31:0]         ph_rest;
    int                  cur_entry;
    t_phase              cur_phase;
    logic                seq_running;
    logic [31:0]         cfg_boost;
    logic [31:0]         cfg_hold;
    logic [6:0]          cfg_len;

    t_valve_state        valve_state_q [$];
    int                  errors         = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_off_left  = 0;

    dispense_valve_phase_sequencer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_entry_index     (i_entry_index),
        .i_entry_value     (i_entry_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_boost_valve     (o_boost_valve),
        .o_main_valve_mode (o_main_valve_mode),
        .o_running         (o_running),
        .o_phase           (o_phase),
        .o_step_position   (o_step_position)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequencer predictor
    // ------------------------------------------------------------------------
    function automatic int used_len();
        int n;
        n = int'(cfg_len);
        return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    endfunction

    function automatic void park_idle();
        cur_phase = PH_IDLE;
        ph_ticks  = '0;
        ph_rest   = '0;
        cur_entry = 0;
    endfunction

    function automatic bit load_main_phase();
        logic [31:0] rest;
        logic [31:0] steady;
        rest = ph_rest;
        if (rest == '0) return 1'b0;
        steady = (cfg_hold == HOLD_NO_PULSE || rest <= cfg_hold) ? rest : cfg_hold;
        if (steady != '0) begin
            cur_phase = PH_STEADY;
            ph_ticks  = steady;
            ph_rest   = rest - steady;
        end else begin
            cur_phase = PH_PULSED;
            ph_ticks  = rest;
            ph_rest   = '0;
        end
        return 1'b1;
    endfunction

    function automatic bit load_entry(input int e);
        logic [31:0] v;
        logic [31:0] b;
        v         = seq_table[e];
        cur_entry = e;
        if (e % 2 == 1) begin
            if (v == '0) return 1'b0;
            cur_phase = PH_GAP;
            ph_ticks  = v;
            ph_rest   = '0;
            return 1'b1;
        end
        b = (cfg_boost < v) ? cfg_boost : v;
        if (b != '0) begin
            cur_phase = PH_BOOST;
            ph_ticks  = b;
            ph_rest   = v - b;
            return 1'b1;
        end
        ph_rest = v;
        return load_main_phase();
    endfunction

    function automatic void search_from(input int first);
        int n;
        int e;
        n = used_len();
        e = first;
        if (e >= n) e = 0;
        for (int k = 0; k < n; k++) begin
            if (load_entry(e)) return;
            e++;
            if (e >= n) e = 0;
        end
        park_idle();
    endfunction

    function automatic void advance_phase();
        bit more;
        more = 1'b0;
        if (cur_phase == PH_BOOST) begin
            more = load_main_phase();
        end else if (cur_phase == PH_STEADY && ph_rest != '0) begin
            cur_phase = PH_PULSED;
            ph_ticks  = ph_rest;
            ph_rest   = '0;
            more      = 1'b1;
        end
        if (!more) search_from(cur_entry + 1);
    endfunction

    function automatic t_valve_state predict_valve_state(input t_op op, input logic [5:0] idx,
                                                         input logic [31:0] val);
        t_valve_state s;
        case (op)
            OP_TICK: begin
                if (seq_running) begin
                    if (cur_phase == PH_IDLE) begin
                        search_from(0);
                    end else begin
                        if (ph_ticks != '0) ph_ticks = ph_ticks - 1;
                        if (ph_ticks == '0) advance_phase();
                    end
                end
            end
            OP_WRITE: begin
                seq_table[idx] = val;
            end
            OP_START: begin
                seq_running = 1'b1;
                search_from(0);
            end
            default: begin
                seq_running = 1'b0;
                park_idle();
            end
        endcase
        s.boost   = (cur_phase == PH_BOOST);
        s.mode    = (cur_phase == PH_STEADY) ? MODE_STEADY :
                    (cur_phase == PH_PULSED) ? MODE_PULSED : MODE_CLOSED;
        s.running = seq_running;
        s.phase   = cur_phase;
        s.pos     = cur_entry[5:0];
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_sequencer_op(input t_op op, input logic [5:0] idx,
                                     input logic [31:0] val);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_entry_value <= val;
        do @(posedge i_clk); while (o_stall);
        valve_state_q.push_back(predict_valve_state(op, idx, val));
    endtask

    task automatic tick(input int count);
        repeat (count) send_sequencer_op(OP_TICK, 6'($urandom_range(63)), $urandom);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (valve_state_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_BOOST: cfg_boost = v;
            REG_HOLD:  cfg_hold  = v;
            default:   cfg_len   = v[6:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] boost, input logic [31:0] hold,
                              input logic [6:0] len);
        pause_until_drained();
        reg_write(REG_BOOST, boost);
        reg_write(REG_HOLD, hold);
        reg_write(REG_SEQ_LEN, {25'd0, len});
    endtask

    // ------------------------------------------------------------------------
    // output transfer checker and receiver stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_valve_state want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (valve_state_q.size() == 0) begin
                report_mismatch("transfer with nothing pending", 1, 0);
            end else begin
                want = valve_state_q.pop_front();
                if (o_boost_valve !== want.boost)
                    report_mismatch("boost_valve", 32'(o_boost_valve), 32'(want.boost));
                if (o_main_valve_mode !== want.mode)
                    report_mismatch("main_valve_mode", 32'(o_main_valve_mode),
                                    32'(want.mode));
                if (o_running !== want.running)
                    report_mismatch("running", 32'(o_running), 32'(want.running));
                if (o_phase !== want.phase)
                    report_mismatch("phase", 32'(o_phase), 32'(want.phase));
                if (o_step_position !== want.pos)
                    report_mismatch("step_position", 32'(o_step_position), 32'(want.pos));
            end
        end
        if (hold_off_left > 0) begin
            i_stall <= 1'b1;
            hold_off_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_table_load();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_sequencer_op(OP_WRITE, 6'(i), (i % 2) ? 32'(i % 3) : 32'(i % 5 + 1));
    endtask

    task automatic test_phase_sequence();
        set_config(32'd2, 32'd2, 7'd2);
        send_sequencer_op(OP_WRITE, 6'd0, 32'd7);
        send_sequencer_op(OP_WRITE, 6'd1, 32'd2);
        send_sequencer_op(OP_TICK, 6'h3F, 32'hFFFF_FFFF);   // ignored while stopped
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        tick(10);                                           // boost, steady, pulsed, gap, wrap
        send_sequencer_op(OP_START, 6'h3F, 32'hFFFF_FFFF);  // restart while running
        tick(2);
        send_sequencer_op(OP_STOP, 6'h3F, 32'hFFFF_FFFF);
        tick(1);
    endtask

    task automatic test_special_cases();
        set_config(32'd0, 32'd0, 7'd2);                      // straight to pulsed
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        tick(2);
        set_config(32'd1, HOLD_NO_PULSE, 7'd2);              // no pulsing
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        tick(3);
        set_config(32'hFFFF_FFFF, 32'd3, 7'd3);              // boost covers interval, odd length
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        tick(3);
        set_config(32'd0, 32'd3, 7'd0);                      // nothing to do
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        tick(1);
        set_config(32'd1, 32'd1, 7'd4);                      // all used entries zero
        for (int i = 0; i < 4; i++) send_sequencer_op(OP_WRITE, 6'(i), 32'd0);
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        send_sequencer_op(OP_WRITE, 6'd2, 32'd3);
        tick(2);
        send_sequencer_op(OP_WRITE, 6'd63, 32'hFFFF_FFFF);
        set_config(32'd1, 32'd1, 7'd127);                    // length clamps to table depth
        tick(2);
        set_config(32'd1, 32'd1, 7'd2);                      // shortened while at entry 4
        tick(2);
        send_sequencer_op(OP_STOP, 6'd0, 32'd0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        int          r;
        t_op         op;
        logic [5:0]  idx;
        logic [31:0] val;
        logic [31:0] b;
        logic [31:0] h;
        logic [6:0]  l;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(7))
                    0, 1:    b = '0;
                    2:       b = $urandom;
                    default: b = $urandom_range(1, 4);
                endcase
                case ($urandom_range(7))
                    0:       h = '0;
                    1:       h = HOLD_NO_PULSE;
                    2:       h = $urandom;
                    default: h = $urandom_range(1, 6);
                endcase
                case ($urandom_range(7))
                    0:       l = 7'd0;
                    1:       l = 7'd64;
                    2:       l = 7'($urandom_range(65, 127));
                    default: l = 7'($urandom_range(1, 12));
                endcase
                set_config(b, h, l);
                send_idle_pct  = send_pct;
                recv_stall_pct = recv_pct;
                send_sequencer_op(OP_START, 6'($urandom_range(63)), $urandom);
            end else begin
                r   = $urandom_range(99);
                idx = 6'($urandom_range(63));
                val = $urandom;
                if (r < 74) begin
                    op = OP_TICK;
                end else if (r < 88) begin
                    op  = OP_WRITE;
                    idx = ($urandom_range(3) != 0) ? 6'($urandom_range(15)) : idx;
                    if (!(idx >= 6'd48 && $urandom_range(3) == 0)) val = $urandom_range(8);
                end else if (r < 96) begin
                    op = OP_START;
                end else begin
                    op = OP_STOP;
                end
                send_sequencer_op(op, idx, val);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_config(32'd1, 32'd2, 7'd6);
        for (int i = 0; i < 6; i++) send_sequencer_op(OP_WRITE, 6'(i), 32'(i % 3 + 2));
        send_sequencer_op(OP_START, 6'd0, 32'd0);
        hold_off_left = 400;
        tick(30);
        pause_until_drained();
        repeat ($urandom_range(5, 40)) @(posedge i_clk);
        tick(5);
        send_sequencer_op(OP_STOP, 6'd0, 32'd0);
    endtask

    initial begin
        int waited;
        for (int i = 0; i < TABLE_DEPTH; i++) seq_table[i] = '0;
        cfg_boost   = BOOST_RESET;
        cfg_hold    = HOLD_RESET;
        cfg_len     = SEQ_LEN_RESET;
        seq_running = 1'b0;
        park_idle();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_phase_sequence();
        test_special_cases();
        test_random_traffic(0, 0, 250);
        test_random_traffic(68, 0, 250);
        test_random_traffic(0, 68, 250);
        test_random_traffic(13, 13, 250);
        test_backpressure();

        i_valid <= 1'b0;
        waited = 0;
        while (valve_state_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (valve_state_q.size() != 0)
            report_mismatch("transfers still pending", valve_state_q.size(), 0);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dvps_pkg.sv
rtl/core/dvps_regs.sv
rtl/core/dispense_valve_phase_sequencer.sv
tb/sv/tb_top.sv
